// ----- src/mdws_pkg.sv -----
// Shared types, constants and table functions for the double-well sampler.
package mdws_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROP,
        ST_SUM,
        ST_DIFF,
        ST_SQ,
        ST_W,
        ST_Y,
        ST_LOG,
        ST_EXP,
        ST_AMP,
        ST_TERM,
        ST_DE,
        ST_BY,
        ST_BCHK,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        CFG_SPREAD  = 3'd0,
        CFG_BETA    = 3'd1,
        CFG_AMP_A   = 3'd2,
        CFG_MEAN_A  = 3'd3,
        CFG_WIDTH_A = 3'd4,
        CFG_AMP_B   = 3'd5,
        CFG_MEAN_B  = 3'd6,
        CFG_WIDTH_B = 3'd7
    } t_cfg_idx;

    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int EXP_W  = 17;
    localparam int Y_W    = 20;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned rem;
        int k;
        r   = 64'd0;
        b   = 64'd1 << 62;
        rem = v;
        for (k = 0; k < 32; k++) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Table entry 2^(-x) for Q0.16 x, built from a chain of Q0.32 roots.
    function automatic logic [EXP_W-1:0] exp_entry(input longint unsigned x);
        longint unsigned roots [16];
        longint unsigned r;
        longint unsigned v;
        longint unsigned e;
        int k;
        r = 64'd1 << 31;
        for (k = 0; k < 16; k++) begin
            r = isqrt64(r << 32);
            roots[k] = r;
        end
        v = 64'd1 << 32;
        for (k = 0; k < 16; k++) begin
            if (((x >> (15 - k)) & 64'd1) != 64'd0) begin
                v = (v * roots[k]) >> 32;
            end
        end
        e = (v + 64'd32768) >> 16;
        return e[EXP_W-1:0];
    endfunction

endpackage

// ----- src/metropolis_double_well_sampler.sv -----
// Top level: one Metropolis step per request on a Q16.16 position in a double well.
// A step request runs the proposal, four well terms (position before and after the
// move, two wells each; shorter when a term is certainly zero or a width is zero) and
// the acceptance exponential (skipped when the energy does not rise or the step is
// rejected outright), all through one shared 34x34 multiplier. The input stalls until
// the result is registered; the result sits in an output register, so the next request
// is taken while it waits, but a step that finishes while the previous result is still
// stalled holds until that one leaves. A load request gives no result. Configuration
// writes are always ready.
module metropolis_double_well_sampler
    import mdws_pkg::*;
#(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic signed [31:0] i_start_position,
    input  logic signed [15:0] i_normal_noise,
    input  logic [15:0]        i_uniform_draw,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_position,
    output logic signed [16:0] o_energy,
    output logic               o_accepted,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0]        r_spread, r_beta, r_width_a, r_width_b;
    logic signed [15:0] r_amp_a, r_amp_b;
    logic signed [31:0] r_mean_a, r_mean_b;
    logic signed [31:0] r_pos, n_pos;

    logic signed [15:0] r_noise, n_noise;
    logic [15:0]        r_unif, n_unif;
    logic signed [31:0] r_s1, n_s1;
    logic [32:0]        r_ad, n_ad;
    logic [Y_W-1:0]     r_y, n_y;
    logic [EXP_W-1:0]   r_exp, n_exp;
    logic signed [16:0] r_e0, n_e0, r_e1, n_e1;
    logic signed [17:0] r_de, n_de;
    logic               r_pt, n_pt, r_well, n_well, r_accph, n_accph, r_take, n_take;

    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_opos, n_opos;
    logic signed [16:0] r_oen, n_oen;
    logic               r_oacc, n_oacc;

    logic signed [MUL_W-1:0]  w_a, w_b;
    logic signed [PROD_W-1:0] w_p;
    logic [EXP_W-1:0]         w_lut;

    logic               w_in_acc, w_out_acc;
    logic signed [32:0] w_rnd;
    logic signed [28:0] w_delta;
    logic signed [33:0] w_sum;
    logic signed [31:0] w_x, w_mean;
    logic signed [33:0] w_d;
    logic [15:0]        w_width;
    logic signed [15:0] w_amp;
    logic signed [16:0] w_term;

    assign w_in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_acc = r_ovalid && !i_out_stall;

    mdws_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    mdws_exp_lut #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_exp (
        .i_frac  (w_p[31:16]),
        .i_shift (w_p[36:32]),
        .o_value (w_lut)
    );

    // Operand selects for the current point and well.
    assign w_x     = r_pt ? r_s1 : r_pos;
    assign w_mean  = r_well ? r_mean_b : r_mean_a;
    assign w_width = r_well ? r_width_b : r_width_a;
    assign w_amp   = r_well ? r_amp_b : r_amp_a;
    assign w_d     = 34'(w_x) - 34'(w_mean);
    assign w_rnd   = w_p[32:0] + 33'sd8;
    assign w_delta = w_rnd[32:4];
    assign w_sum   = 34'(r_pos) + 34'(w_delta);
    assign w_term  = w_p[32:16];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid && !i_func) n_state = ST_PROP;
            ST_PROP: n_state = ST_SUM;
            ST_SUM:  n_state = ST_DIFF;
            ST_DIFF: n_state = ST_SQ;
            ST_SQ:   n_state = ST_W;
            ST_W: begin
                if (w_width == 16'd0) begin
                    n_state = ST_LOG;
                end else if (|w_p[63:44]) begin
                    n_state = ST_AMP;
                end else begin
                    n_state = ST_Y;
                end
            end
            ST_Y:    n_state = (|w_p[43:28]) ? ST_AMP : ST_LOG;
            ST_LOG:  n_state = ST_EXP;
            ST_EXP:  n_state = r_accph ? ST_OUT : ST_AMP;
            ST_AMP:  n_state = ST_TERM;
            ST_TERM: n_state = (r_pt && r_well) ? ST_DE : ST_DIFF;
            ST_DE:   n_state = (r_de <= 18'sd0) ? ST_OUT : ST_BY;
            ST_BY:   n_state = ST_BCHK;
            ST_BCHK: n_state = (|w_p[33:20]) ? ST_OUT : ST_LOG;
            ST_OUT:  if (!r_ovalid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_a      = '0;
        w_b      = '0;
        n_pos    = r_pos;
        n_noise  = r_noise;
        n_unif   = r_unif;
        n_s1     = r_s1;
        n_ad     = r_ad;
        n_y      = r_y;
        n_exp    = r_exp;
        n_e0     = r_e0;
        n_e1     = r_e1;
        n_de     = r_de;
        n_pt     = r_pt;
        n_well   = r_well;
        n_accph  = r_accph;
        n_take   = r_take;
        n_ovalid = w_out_acc ? 1'b0 : r_ovalid;
        n_opos   = r_opos;
        n_oen    = r_oen;
        n_oacc   = r_oacc;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_func) begin
                        n_pos = i_start_position;
                    end
                    n_noise = i_normal_noise;
                    n_unif  = i_uniform_draw;
                end
            end
            ST_PROP: begin
                w_a = MUL_W'(r_spread);
                w_b = MUL_W'(r_noise);
            end
            ST_SUM: begin
                if (w_sum > 34'sd2147483647) begin
                    n_s1 = 32'sh7FFFFFFF;
                end else if (w_sum < -34'sd2147483648) begin
                    n_s1 = 32'sh80000000;
                end else begin
                    n_s1 = w_sum[31:0];
                end
                n_pt    = 1'b0;
                n_well  = 1'b0;
                n_accph = 1'b0;
                n_e0    = '0;
                n_e1    = '0;
            end
            ST_DIFF: begin
                n_ad = w_d[33] ? 33'(-w_d) : w_d[32:0];
            end
            ST_SQ: begin
                w_a = MUL_W'(r_ad);
                w_b = MUL_W'(r_ad);
            end
            ST_W: begin
                // Zero width gives exp of zero; a large square kills the term.
                if (w_width == 16'd0) begin
                    n_y = '0;
                end else if (|w_p[63:44]) begin
                    n_exp = '0;
                end else begin
                    w_a = MUL_W'(w_p[43:16]);
                    w_b = MUL_W'(w_width);
                end
            end
            ST_Y: begin
                n_exp = '0;
                n_y   = w_p[27:8];
            end
            ST_LOG: begin
                w_a = MUL_W'(r_y);
                w_b = MUL_W'(LOG2E_Q16);
            end
            ST_EXP: begin
                n_exp = w_lut;
                if (r_accph) begin
                    n_take = {1'b0, r_unif} < w_lut;
                end
            end
            ST_AMP: begin
                w_a = MUL_W'(w_amp);
                w_b = MUL_W'(r_exp);
            end
            ST_TERM: begin
                if (r_pt) begin
                    n_e1 = r_e1 + w_term;
                end else begin
                    n_e0 = r_e0 + w_term;
                end
                n_well = !r_well;
                if (r_well) begin
                    n_pt = 1'b1;
                end
            end
            ST_DE: begin
                n_de = 18'(r_e1) - 18'(r_e0);
                if (r_de <= 18'sd0) begin
                    n_take = 1'b1;
                end
            end
            ST_BY: begin
                w_a     = MUL_W'(r_beta);
                w_b     = MUL_W'(r_de);
                n_accph = 1'b1;
                n_take  = 1'b0;
            end
            ST_BCHK: begin
                // Reject outright when beta * dE reaches 16.0.
                if (!(|w_p[33:20])) begin
                    n_y = w_p[19:0];
                end
            end
            ST_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_opos   = r_take ? r_s1 : r_pos;
                    n_pos    = r_take ? r_s1 : r_pos;
                    n_oen    = r_e0;
                    n_oacc   = r_take;
                end
            end
            default: ;
        endcase
    end

    // The difference is registered in ST_TERM, ahead of its test in ST_DE.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_pos     <= '0;
            r_spread  <= 16'd256;
            r_beta    <= 16'd256;
            r_amp_a   <= '0;
            r_mean_a  <= '0;
            r_width_a <= 16'd128;
            r_amp_b   <= '0;
            r_mean_b  <= '0;
            r_width_b <= 16'd128;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pos    <= n_pos;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SPREAD:  r_spread  <= i_cfg_data[15:0];
                    CFG_BETA:    r_beta    <= i_cfg_data[15:0];
                    CFG_AMP_A:   r_amp_a   <= i_cfg_data[15:0];
                    CFG_MEAN_A:  r_mean_a  <= i_cfg_data;
                    CFG_WIDTH_A: r_width_a <= i_cfg_data[15:0];
                    CFG_AMP_B:   r_amp_b   <= i_cfg_data[15:0];
                    CFG_MEAN_B:  r_mean_b  <= i_cfg_data;
                    CFG_WIDTH_B: r_width_b <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_noise <= n_noise;
        r_unif  <= n_unif;
        r_s1    <= n_s1;
        r_ad    <= n_ad;
        r_y     <= n_y;
        r_exp   <= n_exp;
        r_e0    <= n_e0;
        r_e1    <= n_e1;
        r_de    <= (r_state == ST_TERM) ? 18'(n_e1) - 18'(n_e0) : n_de;
        r_pt    <= n_pt;
        r_well  <= n_well;
        r_accph <= n_accph;
        r_take  <= n_take;
        r_opos  <= n_opos;
        r_oen   <= n_oen;
        r_oacc  <= n_oacc;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_position  = r_opos;
    assign o_energy    = r_oen;
    assign o_accepted  = r_oacc;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- src/mdws_mul.sv -----
// Shared signed multiplier with a registered product.
module mdws_mul
    import mdws_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- src/mdws_exp_lut.sv -----
// Fraction table of 2^(-f) with an integer right shift, Q1.16 result.
module mdws_exp_lut
    import mdws_pkg::*;
#(
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic [15:0]      i_frac,
    input  logic [4:0]       i_shift,
    output logic [EXP_W-1:0] o_value
);

    localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
    localparam int SCL_W = 16 + IDX_W + 1;

    logic [EXP_W-1:0] w_tab [EXP_TABLE_ENTRIES];
    logic [SCL_W-1:0] w_scaled;
    logic [IDX_W-1:0] w_idx;

    for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_tab
        localparam longint unsigned X = (longint'(g) * 65536) / EXP_TABLE_ENTRIES;
        assign w_tab[g] = exp_entry(X);
    end

    assign w_scaled = SCL_W'(i_frac) * SCL_W'(EXP_TABLE_ENTRIES);
    assign w_idx    = w_scaled[16 +: IDX_W];
    assign o_value  = w_tab[w_idx] >> i_shift;

endmodule
